// ----- design/dvad_pkg.sv -----
package dvad_pkg;

  localparam int AddWidthDef = 16;
  localparam logic [13:0] MaxYearRst = 14'd2023;
  localparam logic [16:0] Recip100 = 17'd41944;
  localparam int RecipShift = 22;
  localparam logic [6:0] CenturyLast = 7'd99;
  localparam logic [3:0] MonthDec = 4'd12;
  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;

  typedef struct packed {
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
    logic [15:0] days_to_add;
  } in_t;

  typedef struct packed {
    logic        date_valid;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_CHECK,
    ST_ITER,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic quot;
    logic rem;
    logic check;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic more;
  } status_t;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- design/dvad_cfg.sv -----
module dvad_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [13:0] max_year_o
);

  logic [13:0] max_year_q;
  logic [13:0] max_year_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_comb begin
    max_year_d = max_year_q;
    if (wr_en) begin
      max_year_d = pwdata[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_year_q <= dvad_pkg::MaxYearRst;
    end else begin
      max_year_q <= max_year_d;
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {18'd0, max_year_q} : 32'd0;
  assign max_year_o = max_year_q;

endmodule

// ----- design/dvad_ctrl.sv -----
module dvad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  dvad_pkg::status_t status_i,
  output dvad_pkg::cmd_t    cmd_o
);

  dvad_pkg::state_e state_q;
  dvad_pkg::state_e state_d;
  logic             out_valid_q;
  logic             out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = (state_q != dvad_pkg::ST_IDLE);
    case (state_q)
      dvad_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = dvad_pkg::ST_QUOT;
        end
      end
      dvad_pkg::ST_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d = dvad_pkg::ST_REM;
      end
      dvad_pkg::ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d = dvad_pkg::ST_CHECK;
      end
      dvad_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = dvad_pkg::ST_ITER;
      end
      dvad_pkg::ST_ITER: begin
        if (status_i.more) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = dvad_pkg::ST_DONE;
        end
      end
      dvad_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d = dvad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dvad_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dvad_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/dvad_dp.sv -----
module dvad_dp #(
  parameter int ADD_WIDTH = dvad_pkg::AddWidthDef
) (
  input  logic              clk_i,
  input  dvad_pkg::in_t     in_data_i,
  input  logic [13:0]       max_year_i,
  input  dvad_pkg::cmd_t    cmd_i,
  output dvad_pkg::status_t status_o,
  output dvad_pkg::out_t    out_data_o
);

  localparam int NW = (ADD_WIDTH < 16) ? ADD_WIDTH : 16;
  localparam int DW = NW + 1;

  logic [4:0]    day_q;
  logic [3:0]    m_q;
  logic [13:0]   y_q;
  logic [NW-1:0] n_q;
  logic [7:0]    q100_q;
  logic [6:0]    r100_q;
  logic          valid_q;
  logic [DW-1:0] d_q;
  dvad_pkg::out_t out_q;

  logic [30:0]   prod;
  logic [13:0]   rem_full;
  logic          leap;
  logic [4:0]    len;
  logic          date_ok;

  assign prod = 31'(y_q) * 31'(dvad_pkg::Recip100);
  assign rem_full = y_q - 14'(14'(q100_q) * 14'd100);
  assign leap = (y_q[1:0] == 2'd0) && ((r100_q != 7'd0) || (q100_q[1:0] == 2'd0));
  assign len = dvad_pkg::days_in(m_q, leap);
  assign date_ok = (y_q <= max_year_i) && (m_q inside {[4'd1:4'd12]}) &&
                   (day_q != 5'd0) && (day_q <= len);
  assign status_o.more = valid_q && (d_q > DW'(len));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q <= in_data_i.day_in;
      m_q <= in_data_i.month_in;
      y_q <= in_data_i.year_in;
      n_q <= in_data_i.days_to_add[NW-1:0];
    end
    if (cmd_i.quot) begin
      q100_q <= prod[dvad_pkg::RecipShift+7:dvad_pkg::RecipShift];
    end
    if (cmd_i.rem) begin
      r100_q <= rem_full[6:0];
    end
    if (cmd_i.check) begin
      valid_q <= date_ok;
      d_q <= DW'(day_q) + DW'(n_q);
    end
    if (cmd_i.step) begin
      d_q <= d_q - DW'(len);
      if (m_q == dvad_pkg::MonthDec) begin
        m_q <= dvad_pkg::MonthJan;
        if (y_q == 14'h3FFF) begin
          y_q <= 14'd0;
          r100_q <= 7'd0;
          q100_q <= 8'd0;
        end else begin
          y_q <= y_q + 14'd1;
          if (r100_q == dvad_pkg::CenturyLast) begin
            r100_q <= 7'd0;
            q100_q <= q100_q + 8'd1;
          end else begin
            r100_q <= r100_q + 7'd1;
          end
        end
      end else begin
        m_q <= m_q + 4'd1;
      end
    end
    if (cmd_i.emit) begin
      out_q.date_valid <= valid_q;
      out_q.day_out <= valid_q ? d_q[4:0] : 5'd0;
      out_q.month_out <= valid_q ? m_q : 4'd0;
      out_q.year_out <= valid_q ? y_q : 14'd0;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- design/date_validate_add_days_unit.sv -----
// The unit loads an accepted input, forms the century quotient and
// remainder, checks the date, carries whole months, one month per cycle,
// and emits the result. No new input is taken until the result is emitted.
// A finished result waits in an output register while a new input is taken.
// Reset is asynchronous and active low; it sets max_year to 2023.
module date_validate_add_days_unit #(
  parameter int ADD_WIDTH = dvad_pkg::AddWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dvad_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dvad_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [13:0]       max_year;
  dvad_pkg::cmd_t    cmd;
  dvad_pkg::status_t status;

  dvad_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_year_o (max_year)
  );

  dvad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dvad_dp #(
    .ADD_WIDTH (ADD_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .max_year_i (max_year),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
